### hw/rtl/apbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbf_pkg
// Shared transaction types and codes of the articulation point / bridge finder.
// ----------------------------------------------------------------------------
package apbf_pkg;

  // configuration register width and reset value
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;

  // vertex id width of the fields and of one stored edge
  localparam int ID_W   = 4;
  localparam int EDGE_W = 2 * ID_W;

  // input mode codes
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  // result kind codes
  localparam logic [1:0] KIND_CUT    = 2'd0;
  localparam logic [1:0] KIND_BRIDGE = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] end_a;
    logic [ID_W-1:0] end_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] node_first;
    logic [ID_W-1:0] node_second;
    logic            overflow;
    logic            last;
  } out_item_t;

endpackage

### hw/rtl/apbf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbf_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module apbf_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/articulation_point_bridge_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// articulation_point_bridge_finder_unit
// Tarjan low-link search for cut vertices and bridges of an undirected graph.
// ----------------------------------------------------------------------------
// An add transaction stores one edge when it is in range and fits; no
// result follows. A run transaction holds the input stalled while a
// depth-first search walks the edge RAM: every vertex on the stack scans
// 2 x edge_total neighbor slots, each in ST_SCAN and ST_EDGE (plus ST_BACK
// when the neighbor is already visited, for the node RAM lookup), then finds
// its list exhausted in ST_SCAN. A push happens in ST_EDGE itself; each tree
// edge passes ST_POP1 and, unless the parent is the root, ST_POP2 when its
// child is popped (stack RAM and node RAM reads). ST_ROOT checks every vertex
// id as a root, and once more to end the search. Results then leave at up to
// one per cycle while out_stall does not hold the output register: a scan of
// cut vertices, a scan of bridge pairs over every vertex-id pair (MAX_NODES
// rounded up to a power of two), then the done transaction.
// ----------------------------------------------------------------------------
module articulation_point_bridge_finder_unit #(
  parameter int MAX_NODES = 16,
  parameter int MAX_EDGES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  apbf_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output apbf_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [apbf_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int VW   = $clog2(MAX_NODES);
  localparam int SPW  = $clog2(MAX_NODES + 1);
  localparam int ETW  = $clog2(MAX_EDGES + 1);
  localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EDEP = (MAX_EDGES > 1) ? MAX_EDGES : 2;
  localparam int CW   = ETW + 1;
  localparam int FW   = VW + CW + EIW;
  localparam int NEW  = 2 * VW;
  localparam int KW   = 2 * VW + 1;
  localparam int CNTW = apbf_pkg::CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROOT, ST_SCAN, ST_EDGE, ST_BACK, ST_POP1, ST_POP2,
    ST_CUTS, ST_BRIDGES, ST_DONE
  } state_t;

  state_t                  state_r;
  logic [CNTW-1:0]         node_count_r;
  logic [ETW-1:0]          total_r;
  logic                    drop_r;
  logic [MAX_NODES-1:0]    visited_r;
  logic [MAX_NODES-1:0]    cut_r;
  logic [MAX_NODES-1:0]    bmat_r [MAX_NODES];
  logic [CNTW-1:0]         root_r;
  logic [VW-1:0]           timer_r;
  logic [SPW-1:0]          sp_r;
  logic [1:0]              rc_r;
  logic [VW-1:0]           top_v_r;
  logic [CW-1:0]           cur_r;
  logic [EIW-1:0]          via_r;
  logic [VW-1:0]           parent_v_r;
  logic [VW-1:0]           disc_u_r;
  logic [VW-1:0]           low_u_r;
  logic [VW-1:0]           v_r;
  logic [CNTW-1:0]         x_r;
  logic [KW-1:0]           k_r;
  logic                    out_valid_r;
  apbf_pkg::out_item_t     out_data_r;

  // memory ports
  logic                         edge_we;
  logic [EIW-1:0]               edge_waddr;
  logic [apbf_pkg::EDGE_W-1:0]  edge_rdata;
  logic                         node_we;
  logic [VW-1:0]                node_raddr;
  logic [NEW-1:0]               node_rdata;
  logic                         stk_we;
  logic [VW-1:0]                stk_waddr;
  logic [VW-1:0]                stk_raddr;
  logic [FW-1:0]                stk_wdata;
  logic [FW-1:0]                stk_rdata;

  // active vertex count: zero acts as one, clipped to MAX_NODES
  logic [CNTW-1:0] n_act;
  always_comb begin
    if (node_count_r == '0) begin
      n_act = CNTW'(1);
    end else if (node_count_r > CNTW'(MAX_NODES)) begin
      n_act = CNTW'(MAX_NODES);
    end else begin
      n_act = node_count_r;
    end
  end

  // input transaction decode
  logic in_acc;
  logic add_ok;
  assign in_acc = in_valid && !in_stall;
  assign add_ok = ({1'b0, in_data.end_a} < n_act) && ({1'b0, in_data.end_b} < n_act) &&
                  (total_r < ETW'(MAX_EDGES));

  // neighbor selection from the edge read in ST_EDGE
  logic [apbf_pkg::ID_W-1:0] ea, eb;
  logic                      e_inr;
  logic                      e_hit;
  logic [VW-1:0]             nb_v;
  logic                      can_push;
  always_comb begin
    ea    = edge_rdata[apbf_pkg::EDGE_W-1:apbf_pkg::ID_W];
    eb    = edge_rdata[apbf_pkg::ID_W-1:0];
    e_inr = ({1'b0, ea} < n_act) && ({1'b0, eb} < n_act);
    nb_v  = '0;
    e_hit = 1'b0;
    if (e_inr) begin
      if (!cur_r[0] && ea[VW-1:0] == top_v_r) begin
        nb_v  = eb[VW-1:0];
        e_hit = 1'b1;
      end else if (cur_r[0] && eb[VW-1:0] == top_v_r) begin
        nb_v  = ea[VW-1:0];
        e_hit = 1'b1;
      end
    end
    if (sp_r >= SPW'(2) && nb_v == parent_v_r) begin
      e_hit = 1'b0;
    end
    can_push = (sp_r < SPW'(MAX_NODES));
  end

  // scan status
  logic           scan_more;
  logic [SPW-1:0] sp_dec;
  assign scan_more = (cur_r < {total_r, 1'b0});
  assign sp_dec    = sp_r - SPW'(1);

  // output slot free
  logic slot_free;
  assign slot_free = !out_valid_r || !out_stall;

  // pop-time values
  logic [VW-1:0] disc_p, low_p;
  logic [VW-1:0] br_lo, br_hi;
  assign disc_p = node_rdata[NEW-1:VW];
  assign low_p  = node_rdata[VW-1:0];
  assign br_lo  = (top_v_r < parent_v_r) ? top_v_r : parent_v_r;
  assign br_hi  = (top_v_r < parent_v_r) ? parent_v_r : top_v_r;

  // back-edge target discovery time, bypass for a self loop on the top vertex
  logic [VW-1:0] disc_v;
  assign disc_v = (v_r == top_v_r) ? disc_u_r : node_rdata[NEW-1:VW];

  // bridge pair scan
  logic [VW-1:0] kx, ky;
  logic          pair_hit;
  assign kx = k_r[2*VW-1:VW];
  assign ky = k_r[VW-1:0];
  always_comb begin
    pair_hit = 1'b0;
    if (kx < ky && CNTW'(ky) < n_act) begin
      pair_hit = bmat_r[kx][ky];
    end
  end

  // memory port control
  assign edge_we    = in_acc && (in_data.mode == apbf_pkg::MODE_ADD) && add_ok;
  assign edge_waddr = total_r[EIW-1:0];
  assign node_we    = (state_r == ST_EDGE && e_hit && !visited_r[nb_v] && can_push) ||
                      (state_r == ST_SCAN && !scan_more);
  assign node_raddr = (state_r == ST_EDGE) ? nb_v : parent_v_r;
  assign stk_we     = (state_r == ST_EDGE) && e_hit && !visited_r[nb_v] && can_push;
  assign stk_waddr  = sp_dec[VW-1:0];
  assign stk_wdata  = {top_v_r, cur_r + CW'(1), via_r};
  assign stk_raddr  = VW'(sp_r - SPW'(2));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= apbf_pkg::NODE_COUNT_RST;
      total_r      <= '0;
      drop_r       <= 1'b0;
      visited_r    <= '0;
      cut_r        <= '0;
      for (int i = 0; i < MAX_NODES; i++) begin
        bmat_r[i] <= '0;
      end
      sp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.mode == apbf_pkg::MODE_ADD) begin
              if (add_ok) begin
                total_r <= total_r + ETW'(1);
              end else begin
                drop_r <= 1'b1;
              end
            end else begin
              visited_r <= '0;
              cut_r     <= '0;
              for (int i = 0; i < MAX_NODES; i++) begin
                bmat_r[i] <= '0;
              end
              root_r  <= '0;
              timer_r <= '0;
              state_r <= ST_ROOT;
            end
          end
        end
        ST_ROOT: begin
          if (root_r == n_act) begin
            x_r     <= '0;
            state_r <= ST_CUTS;
          end else if (visited_r[root_r[VW-1:0]]) begin
            root_r <= root_r + CNTW'(1);
          end else begin
            visited_r[root_r[VW-1:0]] <= 1'b1;
            disc_u_r <= timer_r;
            low_u_r  <= timer_r;
            timer_r  <= timer_r + VW'(1);
            top_v_r  <= root_r[VW-1:0];
            cur_r    <= '0;
            via_r    <= '0;
            sp_r     <= SPW'(1);
            rc_r     <= '0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_more) begin
            state_r <= ST_EDGE;
          end else begin
            // pop: write back top entry, fetch parent frame and entry
            sp_r <= sp_dec;
            if (sp_dec == '0) begin
              root_r  <= root_r + CNTW'(1);
              state_r <= ST_ROOT;
            end else begin
              state_r <= ST_POP1;
            end
          end
        end
        ST_EDGE: begin
          cur_r <= cur_r + CW'(1);
          v_r   <= nb_v;
          if (e_hit) begin
            if (visited_r[nb_v]) begin
              state_r <= ST_BACK;
            end else if (can_push) begin
              visited_r[nb_v] <= 1'b1;
              parent_v_r <= top_v_r;
              top_v_r    <= nb_v;
              disc_u_r   <= timer_r;
              low_u_r    <= timer_r;
              timer_r    <= timer_r + VW'(1);
              cur_r      <= '0;
              via_r      <= cur_r[EIW:1];
              sp_r       <= sp_r + SPW'(1);
              if (sp_r == SPW'(1) && rc_r != 2'd2) begin
                rc_r <= rc_r + 2'd1;
              end
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_SCAN;
            end
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_BACK: begin
          if (disc_v < low_u_r) begin
            low_u_r <= disc_v;
          end
          state_r <= ST_SCAN;
        end
        ST_POP1: begin
          if (low_u_r > disc_p) begin
            bmat_r[br_lo][br_hi] <= 1'b1;
          end
          if ((sp_r >= SPW'(2) && low_u_r >= disc_p) ||
              (sp_r == SPW'(1) && rc_r > 2'd1)) begin
            cut_r[parent_v_r] <= 1'b1;
          end
          low_u_r  <= (low_u_r < low_p) ? low_u_r : low_p;
          disc_u_r <= disc_p;
          top_v_r  <= parent_v_r;
          cur_r    <= stk_rdata[CW+EIW-1:EIW];
          via_r    <= stk_rdata[EIW-1:0];
          state_r  <= (sp_r >= SPW'(2)) ? ST_POP2 : ST_SCAN;
        end
        ST_POP2: begin
          parent_v_r <= stk_rdata[FW-1:CW+EIW];
          state_r    <= ST_SCAN;
        end
        ST_CUTS: begin
          if (x_r == n_act) begin
            k_r     <= '0;
            state_r <= ST_BRIDGES;
          end else if (!cut_r[x_r[VW-1:0]]) begin
            x_r <= x_r + CNTW'(1);
          end else if (slot_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.kind        <= apbf_pkg::KIND_CUT;
            out_data_r.node_first  <= apbf_pkg::ID_W'(x_r[VW-1:0]);
            out_data_r.node_second <= '0;
            out_data_r.overflow    <= 1'b0;
            out_data_r.last        <= 1'b0;
            x_r <= x_r + CNTW'(1);
          end
        end
        ST_BRIDGES: begin
          if (k_r[KW-1]) begin
            state_r <= ST_DONE;
          end else if (!pair_hit) begin
            k_r <= k_r + KW'(1);
          end else if (slot_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.kind        <= apbf_pkg::KIND_BRIDGE;
            out_data_r.node_first  <= apbf_pkg::ID_W'(kx);
            out_data_r.node_second <= apbf_pkg::ID_W'(ky);
            out_data_r.overflow    <= 1'b0;
            out_data_r.last        <= 1'b0;
            k_r <= k_r + KW'(1);
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.kind        <= apbf_pkg::KIND_DONE;
            out_data_r.node_first  <= '0;
            out_data_r.node_second <= '0;
            out_data_r.overflow    <= drop_r;
            out_data_r.last        <= 1'b1;
            total_r   <= '0;
            drop_r    <= 1'b0;
            visited_r <= '0;
            cut_r     <= '0;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // edge store
  apbf_ram #(.DEPTH(EDEP), .WIDTH(apbf_pkg::EDGE_W)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata ({in_data.end_a, in_data.end_b}),
    .raddr (cur_r[EIW:1]),
    .rdata (edge_rdata)
  );

  // discovery time / low link table
  apbf_ram #(.DEPTH(MAX_NODES), .WIDTH(NEW)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (top_v_r),
    .wdata ({disc_u_r, low_u_r}),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // search stack below the top frame
  apbf_ram #(.DEPTH(MAX_NODES), .WIDTH(FW)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule
